FILE: hw/rtl/lmt_pkg.sv
package lmt_pkg;

  localparam int MARKERS    = 32;
  localparam int LINE_BITS  = 24;
  localparam int ID_BITS    = 16;
  localparam int FILE_BITS  = 8;
  localparam int KIND_BITS  = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  localparam logic [KIND_BITS-1:0] K_SET    = 3'd0;
  localparam logic [KIND_BITS-1:0] K_GET    = 3'd1;
  localparam logic [KIND_BITS-1:0] K_REMOVE = 3'd2;
  localparam logic [KIND_BITS-1:0] K_INSERT = 3'd3;
  localparam logic [KIND_BITS-1:0] K_DELETE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_OTHER     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // register select is paddr[2]
  localparam logic REG_CURRENT_FILE = 1'b0;
  localparam logic REG_LOADING      = 1'b1;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   marker_id;
    logic [LINE_BITS-1:0] line_number;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [LINE_BITS-1:0] line_value;
    logic [LINE_BITS-1:0] line_total;
  } out_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [LINE_BITS-1:0] line;
    logic [FILE_BITS-1:0] file;
  } entry_t;

endpackage

FILE: hw/rtl/line_marker_table.sv
// Line marker table: holds up to MARKERS (id, line, file) marks in one RAM plus the
// file's line count. One request is taken at a time; in_stall stays high until its
// result has been loaded into the output register (a waiting result does not block
// the next request). Set, get and remove walk the RAM through its single read port,
// one entry per cycle, until the id is found; remove then moves the tail down. Line
// insert and delete walk every entry to adjust its line, except when loading or when
// a delete is ignored. No clearing pass after reset.
module line_marker_table #(
  parameter int MARKERS = lmt_pkg::MARKERS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lmt_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lmt_pkg::out_t                      out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lmt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [lmt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [lmt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int CNT_W = $clog2(MARKERS + 1);
  localparam int IDX_W = (MARKERS > 1) ? $clog2(MARKERS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_ADJ   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [CNT_W-1:0]                    count_r, count_nxt;
  logic [CNT_W-1:0]                    walk_r, walk_nxt;
  logic                                pend_r, pend_nxt;
  logic [IDX_W-1:0]                    rd_idx_r, rd_idx_nxt;
  logic [lmt_pkg::LINE_BITS-1:0]       lines_r, lines_nxt;
  lmt_pkg::in_t                        req_r, req_nxt;
  logic [1:0]                          status_r, status_nxt;
  logic [lmt_pkg::LINE_BITS-1:0]       value_r, value_nxt;
  logic                                out_valid_r, out_valid_nxt;
  lmt_pkg::out_t                       out_data_r, out_data_nxt;
  logic [lmt_pkg::FILE_BITS-1:0]       cur_file_r;
  logic                                loading_r;

  logic                                re, we;
  logic [IDX_W-1:0]                    raddr, waddr;
  lmt_pkg::entry_t                     wdata, rd_entry, new_entry, adj_entry;
  logic                                hit;
  logic                                cfg_wr;

  lmt_ram #(
    .WIDTH($bits(lmt_pkg::entry_t)),
    .DEPTH(MARKERS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rd_entry)
  );

  // configuration
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_file_r <= '0;
      loading_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        lmt_pkg::REG_CURRENT_FILE: cur_file_r <= pwdata[lmt_pkg::FILE_BITS-1:0];
        lmt_pkg::REG_LOADING:      loading_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lmt_pkg::REG_CURRENT_FILE:
        prdata = {{(lmt_pkg::CFG_DATA_W - lmt_pkg::FILE_BITS){1'b0}}, cur_file_r};
      lmt_pkg::REG_LOADING:
        prdata = {{(lmt_pkg::CFG_DATA_W - 1){1'b0}}, loading_r};
      default:
        prdata = '0;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign hit = pend_r && (rd_entry.id == req_r.marker_id);

  always_comb begin
    new_entry.id   = req_r.marker_id;
    new_entry.line = req_r.line_number;
    new_entry.file = cur_file_r;
  end

  always_comb begin
    adj_entry = rd_entry;
    if (rd_entry.file == cur_file_r) begin
      if (req_r.kind == lmt_pkg::K_INSERT) begin
        if (rd_entry.line >= req_r.line_number && rd_entry.line != lmt_pkg::LINE_MAX) begin
          adj_entry.line = rd_entry.line + lmt_pkg::LINE_BITS'(1);
        end
      end else if (rd_entry.line > req_r.line_number) begin
        adj_entry.line = rd_entry.line - lmt_pkg::LINE_BITS'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    walk_nxt      = walk_r;
    pend_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    lines_nxt     = lines_r;
    req_nxt       = req_r;
    status_nxt    = status_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    re            = 1'b0;
    raddr         = walk_r[IDX_W-1:0];
    we            = 1'b0;
    waddr         = rd_idx_r;
    wdata         = rd_entry;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          walk_nxt   = '0;
          status_nxt = lmt_pkg::ST_OK;
          value_nxt  = '0;
          case (in_data.kind)
            lmt_pkg::K_SET, lmt_pkg::K_GET, lmt_pkg::K_REMOVE: begin
              state_nxt = S_SCAN;
            end
            lmt_pkg::K_INSERT: begin
              if (lines_r != lmt_pkg::LINE_MAX) begin
                lines_nxt = lines_r + lmt_pkg::LINE_BITS'(1);
              end
              state_nxt = loading_r ? S_OUT : S_ADJ;
            end
            lmt_pkg::K_DELETE: begin
              if (in_data.line_number < lines_r) begin
                lines_nxt = lines_r - lmt_pkg::LINE_BITS'(1);
                state_nxt = loading_r ? S_OUT : S_ADJ;
              end else begin
                state_nxt = S_OUT;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          case (req_r.kind)
            lmt_pkg::K_SET: begin
              we        = 1'b1;
              wdata     = new_entry;
              state_nxt = S_OUT;
            end
            lmt_pkg::K_GET: begin
              if (rd_entry.file != cur_file_r) begin
                status_nxt = lmt_pkg::ST_OTHER;
              end else begin
                value_nxt = rd_entry.line;
              end
              state_nxt = S_OUT;
            end
            lmt_pkg::K_REMOVE: begin
              count_nxt = count_r - CNT_W'(1);
              walk_nxt  = CNT_W'(rd_idx_r) + CNT_W'(1);
              state_nxt = S_SHIFT;
            end
            default: state_nxt = S_OUT;
          endcase
        end else if (walk_r < count_r) begin
          re         = 1'b1;
          pend_nxt   = 1'b1;
          rd_idx_nxt = walk_r[IDX_W-1:0];
          walk_nxt   = walk_r + CNT_W'(1);
        end else begin
          if (req_r.kind == lmt_pkg::K_SET) begin
            if (count_r < CNT_W'(MARKERS)) begin
              we        = 1'b1;
              waddr     = count_r[IDX_W-1:0];
              wdata     = new_entry;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              status_nxt = lmt_pkg::ST_FULL;
            end
          end else begin
            status_nxt = lmt_pkg::ST_NOT_FOUND;
          end
          state_nxt = S_OUT;
        end
      end

      // count already holds the reduced size; entries up to index count move down
      S_SHIFT: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = rd_idx_r - IDX_W'(1);
        end
        if (walk_r <= count_r) begin
          re         = 1'b1;
          pend_nxt   = 1'b1;
          rd_idx_nxt = walk_r[IDX_W-1:0];
          walk_nxt   = walk_r + CNT_W'(1);
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_ADJ: begin
        if (pend_r) begin
          we    = 1'b1;
          wdata = adj_entry;
        end
        if (walk_r < count_r) begin
          re         = 1'b1;
          pend_nxt   = 1'b1;
          rd_idx_nxt = walk_r[IDX_W-1:0];
          walk_nxt   = walk_r + CNT_W'(1);
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.line_value = value_r;
          out_data_nxt.line_total = lines_r;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lines_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lines_r     <= lines_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r     <= walk_nxt;
    rd_idx_r   <= rd_idx_nxt;
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: hw/rtl/lmt_ram.sv
module lmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/lmt_chk.sv
module lmt_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input lmt_pkg::out_t out_data
);

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  // only a successful lookup carries a line value
  a_value_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != lmt_pkg::ST_OK) |-> (out_data.line_value == '0))
    else $error("line value on failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind line_marker_table lmt_chk u_lmt_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
